[src/incremental_bridge_counter_assert.svh]
// Assertion macros used by the bridge counter RTL.
`ifndef INCREMENTAL_BRIDGE_COUNTER_ASSERT_SVH
`define INCREMENTAL_BRIDGE_COUNTER_ASSERT_SVH
`ifndef SYNTH
`define IBC_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define IBC_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define IBC_ASSERT(lbl, clk, rst, prop, msg)
`define IBC_NEVER(lbl, clk, rst, cond, msg)
`endif
`endif

[src/ibc_pkg.sv]
`timescale 1ns / 1ps
package ibc_pkg;

   localparam int VERTICES_DEF = 1024;
   localparam int EP_W         = 10;
   localparam int COUNT_W      = 10;
   localparam int VCOUNT_W     = 11;
   localparam int EPOCH_W      = 32;
   localparam int CSR_AW       = 3;
   localparam int CSR_DW       = 32;

   typedef enum logic [1:0] {
      EV_IGNORED = 2'd0,
      EV_BRIDGE  = 2'd1,
      EV_MERGED  = 2'd2,
      EV_REJECT  = 2'd3
   } event_type;

   typedef struct packed {
      logic [EP_W-1:0] endpoint_a;
      logic [EP_W-1:0] endpoint_b;
   } req_type;

   typedef struct packed {
      logic [COUNT_W-1:0] bridge_count;
      event_type          event_kind;
      logic [COUNT_W-1:0] bridges_removed;
   } rsp_type;

   typedef enum logic [4:0] {
      ST_INIT,
      ST_IDLE,
      ST_F2_RD,
      ST_F2_CHK,
      ST_GOT_A,
      ST_GOT_B,
      ST_CC_RD,
      ST_CC_CHK,
      ST_GOT_CA,
      ST_GOT_CB,
      ST_RR_RD,
      ST_RR_CHK,
      ST_LINK_RD,
      ST_LINK,
      ST_ADD,
      ST_COL,
      ST_CLR_RD,
      ST_CLR_WR,
      ST_WK_A,
      ST_WA_GOT,
      ST_WK_B,
      ST_WB_GOT,
      ST_SC_RD,
      ST_SC_GOT,
      ST_RP_WR,
      ST_MERGE_END
   } state_type;

endpackage

[src/incremental_bridge_counter.sv]
`timescale 1ns / 1ps
// channel  direction  handshake                payload
// req      in         start & !busy            req_data: endpoint_a, endpoint_b
// rsp      out        rsp_valid, one cycle     rsp_data: bridge_count, event_kind, bridges_removed
// csr      in/out     psel & penable & pwrite  paddr, pwdata, prdata: vertex_count
//
// One transfer in flight. A rejected edge answers in the cycle after it is taken, an
// ignored edge from ST_GOT_B once both endpoint lookups are done. New bridges and
// merges step through each component hop, re-rooted tree vertex, walked path vertex
// and merged path vertex in turn, all through the one read port of the vertex memory.
// After reset busy stays high while ST_INIT writes every vertex memory entry; an
// epoch wrap adds a sweep that clears every mark. The result strobe is never held off.
module incremental_bridge_counter import ibc_pkg::*; #(
   parameter int VERTICES = VERTICES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  req_type           req_data,
   output logic              rsp_valid,
   output rsp_type           rsp_data,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [CSR_AW-1:0] paddr,
   input  logic [CSR_DW-1:0] pwdata,
   output logic [CSR_DW-1:0] prdata,
   output logic              pready
);

   logic [VCOUNT_W-1:0] vertex_count;

   ibc_csr #(.VERTICES(VERTICES)) u_csr (
      .clock        (clock),
      .reset        (reset),
      .psel         (psel),
      .penable      (penable),
      .pwrite       (pwrite),
      .paddr        (paddr),
      .pwdata       (pwdata),
      .prdata       (prdata),
      .pready       (pready),
      .vertex_count (vertex_count)
   );

   ibc_ctrl #(.VERTICES(VERTICES)) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_data     (req_data),
      .vertex_count (vertex_count),
      .rsp_valid    (rsp_valid),
      .rsp_data     (rsp_data)
   );

endmodule

[src/ibc_ram.sv]
`timescale 1ns / 1ps
module ibc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

[src/ibc_csr.sv]
`timescale 1ns / 1ps
module ibc_csr import ibc_pkg::*; #(
   parameter int VERTICES = VERTICES_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [CSR_AW-1:0]   paddr,
   input  logic [CSR_DW-1:0]   pwdata,
   output logic [CSR_DW-1:0]   prdata,
   output logic                pready,
   output logic [VCOUNT_W-1:0] vertex_count
);

   logic [VCOUNT_W-1:0] vcount_ff;
   logic [VCOUNT_W-1:0] vcount_in;
   logic                sel_vcount;

   assign sel_vcount = (paddr[CSR_AW-1] == 1'b0);

   always_comb begin
      vcount_in = vcount_ff;
      if (psel && penable && pwrite && sel_vcount) begin
         vcount_in = pwdata[VCOUNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vcount_ff <= VCOUNT_W'(VERTICES);
      end else begin
         vcount_ff <= vcount_in;
      end
   end

   assign prdata       = sel_vcount ? CSR_DW'(vcount_ff) : '0;
   assign pready       = 1'b1;
   assign vertex_count = vcount_ff;

endmodule

[src/ibc_ctrl.sv]
`timescale 1ns / 1ps
`include "incremental_bridge_counter_assert.svh"
module ibc_ctrl import ibc_pkg::*; #(
   parameter int VERTICES = VERTICES_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  req_type             req_data,
   input  logic [VCOUNT_W-1:0] vertex_count,
   output logic                rsp_valid,
   output rsp_type             rsp_data
);

   localparam int VW = $clog2(VERTICES);
   localparam int SW = VW + 1;

   typedef struct packed {
      logic                pnone;
      logic [VW-1:0]       parent;
      logic [VW-1:0]       l2;
      logic [VW-1:0]       cc;
      logic [VW:0]         size;
      logic [EPOCH_W-1:0]  mark;
   } vword_type;

   localparam int WORD_W = $bits(vword_type);

   state_type state_ff, state_in, f2_ret_ff, f2_ret_in, cc_ret_ff, cc_ret_in;

   logic [VW-1:0]      cur_ff, cur_in, a_ff, a_in, b_ff, b_in;
   logic [VW-1:0]      ca_ff, ca_in, cb_ff, cb_in;
   logic [VW-1:0]      below_ff, below_in, meet_ff, meet_in;
   logic               below_none_ff, below_none_in;
   logic [VW:0]        sza_ff, sza_in;
   logic [VW-1:0]      ap_ff, ap_in, bp_ff, bp_in;
   logic               ap_none_ff, ap_none_in, bp_none_ff, bp_none_in;
   logic [VW-1:0]      na_ff, na_in, nb_ff, nb_in, idx_ff, idx_in;
   logic               side_ff, side_in;
   logic [VW-1:0]      removed_ff, removed_in, bridge_ff, bridge_in;
   logic [EPOCH_W-1:0] epoch_ff, epoch_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   logic              vm_we, vm_re;
   logic [VW-1:0]     vm_waddr, vm_raddr;
   vword_type         vm_wdata, vrd;
   logic [WORD_W-1:0] vm_rdata;

   logic          sm_we, sm_re;
   logic [SW-1:0] sm_waddr, sm_raddr;
   logic [VW-1:0] sm_wdata, srd;

   logic               range_bad, f2_hit, cc_hit, swap, mark_hit, side_empty;
   logic               s_is_meet, sweep_last, epoch_wrap;
   logic [EPOCH_W-1:0] epoch_inc;
   logic [VW-1:0]      bridge_sub;
   logic [SW-1:0]      sb_base;

   ibc_ram #(.WIDTH(WORD_W), .DEPTH(VERTICES)) u_vram (
      .clock (clock),
      .we    (vm_we),
      .waddr (vm_waddr),
      .wdata (vm_wdata),
      .re    (vm_re),
      .raddr (vm_raddr),
      .rdata (vm_rdata)
   );

   ibc_ram #(.WIDTH(VW), .DEPTH(2 * VERTICES)) u_sram (
      .clock (clock),
      .we    (sm_we),
      .waddr (sm_waddr),
      .wdata (sm_wdata),
      .re    (sm_re),
      .raddr (sm_raddr),
      .rdata (srd)
   );

   assign vrd = vword_type'(vm_rdata);
   assign sb_base = SW'(VERTICES);

   assign range_bad = (VCOUNT_W'(req_data.endpoint_a) >= vertex_count)
                   || (VCOUNT_W'(req_data.endpoint_b) >= vertex_count)
                   || (32'(req_data.endpoint_a) >= 32'(VERTICES))
                   || (32'(req_data.endpoint_b) >= 32'(VERTICES));
   assign f2_hit     = (vrd.l2 == cur_ff);
   assign cc_hit     = (vrd.cc == cur_ff);
   assign swap       = (sza_ff > vrd.size);
   assign mark_hit   = (vrd.mark == epoch_ff);
   assign side_empty = side_ff ? (idx_ff == nb_ff) : (idx_ff == na_ff);
   assign s_is_meet  = (srd == meet_ff);
   assign sweep_last = (idx_ff == VW'(VERTICES - 1));
   assign epoch_inc  = epoch_ff + EPOCH_W'(1);
   assign epoch_wrap = (epoch_inc == '0);
   assign bridge_sub = (bridge_ff > removed_ff) ? (bridge_ff - removed_ff) : '0;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_INIT:      if (sweep_last) state_in = ST_IDLE;
         ST_IDLE:      if (start && !range_bad) state_in = ST_F2_RD;
         ST_F2_RD:     state_in = ST_F2_CHK;
         ST_F2_CHK:    if (f2_hit) state_in = f2_ret_ff;
         ST_GOT_A:     state_in = ST_F2_RD;
         ST_GOT_B:     state_in = (cur_ff == a_ff) ? ST_IDLE : ST_CC_RD;
         ST_CC_RD:     state_in = ST_CC_CHK;
         ST_CC_CHK:    state_in = cc_hit ? cc_ret_ff : ST_F2_RD;
         ST_GOT_CA:    state_in = ST_CC_RD;
         ST_GOT_CB:    state_in = (cur_ff != ca_ff) ? ST_RR_RD : ST_COL;
         ST_RR_RD:     state_in = ST_RR_CHK;
         ST_RR_CHK:    state_in = vrd.pnone ? ST_LINK_RD : ST_F2_RD;
         ST_LINK_RD:   state_in = ST_LINK;
         ST_LINK:      state_in = ST_ADD;
         ST_ADD:       state_in = ST_IDLE;
         ST_COL:       state_in = epoch_wrap ? ST_CLR_RD : ST_WK_A;
         ST_CLR_RD:    state_in = ST_CLR_WR;
         ST_CLR_WR:    state_in = sweep_last ? ST_WK_A : ST_CLR_RD;
         ST_WK_A: begin
            priority if (ap_none_ff && bp_none_ff) state_in = ST_IDLE;
            else if (ap_none_ff)                   state_in = ST_WK_B;
            else                                   state_in = ST_F2_RD;
         end
         ST_WA_GOT:    state_in = mark_hit ? ST_SC_RD : ST_WK_B;
         ST_WK_B:      state_in = bp_none_ff ? ST_WK_A : ST_F2_RD;
         ST_WB_GOT:    state_in = mark_hit ? ST_SC_RD : ST_WK_A;
         ST_SC_RD: begin
            if (side_empty) begin
               if (side_ff) state_in = ST_MERGE_END;
            end else begin
               state_in = ST_SC_GOT;
            end
         end
         ST_SC_GOT:    state_in = ST_RP_WR;
         ST_RP_WR:     state_in = (s_is_meet && side_ff) ? ST_MERGE_END : ST_SC_RD;
         ST_MERGE_END: state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   // datapath and memory controls
   always_comb begin
      f2_ret_in     = f2_ret_ff;
      cc_ret_in     = cc_ret_ff;
      cur_in        = cur_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      ca_in         = ca_ff;
      cb_in         = cb_ff;
      below_in      = below_ff;
      below_none_in = below_none_ff;
      meet_in       = meet_ff;
      sza_in        = sza_ff;
      ap_in         = ap_ff;
      bp_in         = bp_ff;
      ap_none_in    = ap_none_ff;
      bp_none_in    = bp_none_ff;
      na_in         = na_ff;
      nb_in         = nb_ff;
      idx_in        = idx_ff;
      side_in       = side_ff;
      removed_in    = removed_ff;
      bridge_in     = bridge_ff;
      epoch_in      = epoch_ff;
      rsp_valid_in  = 1'b0;
      rsp_in        = rsp_ff;
      vm_we         = 1'b0;
      vm_re         = 1'b0;
      vm_waddr      = cur_ff;
      vm_raddr      = cur_ff;
      vm_wdata      = vrd;
      sm_we         = 1'b0;
      sm_re         = 1'b0;
      sm_waddr      = SW'(na_ff);
      sm_raddr      = side_ff ? (sb_base + SW'(idx_ff)) : SW'(idx_ff);
      sm_wdata      = cur_ff;
      unique case (state_ff)
         ST_INIT: begin
            vm_we    = 1'b1;
            vm_waddr = idx_ff;
            vm_wdata = '{pnone: 1'b1, parent: '0, l2: idx_ff, cc: idx_ff,
                         size: (VW+1)'(1), mark: '0};
            idx_in   = sweep_last ? '0 : idx_ff + VW'(1);
         end
         ST_IDLE: begin
            if (start) begin
               if (range_bad) begin
                  rsp_valid_in = 1'b1;
                  rsp_in = '{bridge_count: COUNT_W'(bridge_ff), event_kind: EV_REJECT,
                             bridges_removed: '0};
               end else begin
                  cur_in    = VW'(req_data.endpoint_a);
                  b_in      = VW'(req_data.endpoint_b);
                  f2_ret_in = ST_GOT_A;
               end
            end
         end
         ST_F2_RD: vm_re = 1'b1;
         ST_F2_CHK: begin
            if (!f2_hit) begin
               cur_in   = vrd.l2;
               vm_re    = 1'b1;
               vm_raddr = vrd.l2;
            end
         end
         ST_GOT_A: begin
            a_in      = cur_ff;
            cur_in    = b_ff;
            f2_ret_in = ST_GOT_B;
         end
         ST_GOT_B: begin
            b_in = cur_ff;
            if (cur_ff == a_ff) begin
               rsp_valid_in = 1'b1;
               rsp_in = '{bridge_count: COUNT_W'(bridge_ff), event_kind: EV_IGNORED,
                          bridges_removed: '0};
            end else begin
               cur_in    = a_ff;
               cc_ret_in = ST_GOT_CA;
            end
         end
         ST_CC_RD: vm_re = 1'b1;
         ST_CC_CHK: begin
            if (!cc_hit) begin
               cur_in    = vrd.cc;
               f2_ret_in = ST_CC_CHK;
            end
         end
         ST_GOT_CA: begin
            ca_in     = cur_ff;
            sza_in    = vrd.size;
            cur_in    = b_ff;
            cc_ret_in = ST_GOT_CB;
         end
         ST_GOT_CB: begin
            cb_in = cur_ff;
            if (cur_ff != ca_ff) begin
               below_none_in = 1'b1;
               if (swap) begin
                  a_in   = b_ff;
                  b_in   = a_ff;
                  ca_in  = cur_ff;
                  cb_in  = ca_ff;
                  cur_in = b_ff;
               end else begin
                  cur_in = a_ff;
               end
            end else begin
               ap_in      = a_ff;
               bp_in      = b_ff;
               ap_none_in = 1'b0;
               bp_none_in = 1'b0;
               na_in      = '0;
               nb_in      = '0;
            end
         end
         ST_RR_RD: vm_re = 1'b1;
         ST_RR_CHK: begin
            vm_we           = 1'b1;
            vm_wdata.pnone  = below_none_ff;
            vm_wdata.parent = below_ff;
            vm_wdata.cc     = a_ff;
            below_in        = cur_ff;
            below_none_in   = 1'b0;
            if (vrd.pnone) begin
               sza_in = vrd.size;
            end else begin
               cur_in    = vrd.parent;
               f2_ret_in = ST_RR_CHK;
            end
         end
         ST_LINK_RD: begin
            vm_re    = 1'b1;
            vm_raddr = a_ff;
         end
         ST_LINK: begin
            vm_we           = 1'b1;
            vm_waddr        = a_ff;
            vm_wdata.pnone  = 1'b0;
            vm_wdata.parent = b_ff;
            vm_wdata.cc     = b_ff;
            vm_wdata.size   = sza_ff;
            vm_re           = 1'b1;
            vm_raddr        = cb_ff;
         end
         ST_ADD: begin
            vm_we         = 1'b1;
            vm_waddr      = cb_ff;
            vm_wdata.size = vrd.size + sza_ff;
            bridge_in     = bridge_ff + VW'(1);
            rsp_valid_in  = 1'b1;
            rsp_in = '{bridge_count: COUNT_W'(bridge_ff + VW'(1)), event_kind: EV_BRIDGE,
                       bridges_removed: '0};
         end
         ST_COL: begin
            if (epoch_wrap) begin
               idx_in = '0;
            end else begin
               epoch_in = epoch_inc;
            end
         end
         ST_CLR_RD: begin
            vm_re    = 1'b1;
            vm_raddr = idx_ff;
         end
         ST_CLR_WR: begin
            vm_we         = 1'b1;
            vm_waddr      = idx_ff;
            vm_wdata.mark = '0;
            idx_in        = idx_ff + VW'(1);
            if (sweep_last) begin
               epoch_in = EPOCH_W'(1);
            end
         end
         ST_WK_A: begin
            if (ap_none_ff && bp_none_ff) begin
               rsp_valid_in = 1'b1;
               rsp_in = '{bridge_count: COUNT_W'(bridge_ff), event_kind: EV_MERGED,
                          bridges_removed: '0};
            end else if (!ap_none_ff) begin
               cur_in    = ap_ff;
               f2_ret_in = ST_WA_GOT;
            end
         end
         ST_WA_GOT: begin
            sm_we    = 1'b1;
            sm_waddr = SW'(na_ff);
            na_in    = na_ff + VW'(1);
            if (mark_hit) begin
               meet_in    = cur_ff;
               idx_in     = '0;
               side_in    = 1'b0;
               removed_in = '0;
            end else begin
               vm_we         = 1'b1;
               vm_wdata.mark = epoch_ff;
               ap_in         = vrd.parent;
               ap_none_in    = vrd.pnone;
            end
         end
         ST_WK_B: begin
            if (!bp_none_ff) begin
               cur_in    = bp_ff;
               f2_ret_in = ST_WB_GOT;
            end
         end
         ST_WB_GOT: begin
            sm_we    = 1'b1;
            sm_waddr = sb_base + SW'(nb_ff);
            nb_in    = nb_ff + VW'(1);
            if (mark_hit) begin
               meet_in    = cur_ff;
               idx_in     = '0;
               side_in    = 1'b0;
               removed_in = '0;
            end else begin
               vm_we         = 1'b1;
               vm_wdata.mark = epoch_ff;
               bp_in         = vrd.parent;
               bp_none_in    = vrd.pnone;
            end
         end
         ST_SC_RD: begin
            if (side_empty) begin
               if (!side_ff) begin
                  side_in = 1'b1;
                  idx_in  = '0;
               end
            end else begin
               sm_re = 1'b1;
            end
         end
         ST_SC_GOT: begin
            vm_re    = 1'b1;
            vm_raddr = srd;
         end
         ST_RP_WR: begin
            vm_we       = 1'b1;
            vm_waddr    = srd;
            vm_wdata.l2 = meet_ff;
            if (s_is_meet) begin
               side_in = 1'b1;
               idx_in  = '0;
            end else begin
               removed_in = removed_ff + VW'(1);
               idx_in     = idx_ff + VW'(1);
            end
         end
         ST_MERGE_END: begin
            bridge_in    = bridge_sub;
            rsp_valid_in = 1'b1;
            rsp_in = '{bridge_count: COUNT_W'(bridge_sub), event_kind: EV_MERGED,
                       bridges_removed: COUNT_W'(removed_ff)};
         end
         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         idx_ff       <= '0;
         bridge_ff    <= '0;
         epoch_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         bridge_ff    <= bridge_in;
         epoch_ff     <= epoch_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      f2_ret_ff     <= f2_ret_in;
      cc_ret_ff     <= cc_ret_in;
      cur_ff        <= cur_in;
      a_ff          <= a_in;
      b_ff          <= b_in;
      ca_ff         <= ca_in;
      cb_ff         <= cb_in;
      below_ff      <= below_in;
      below_none_ff <= below_none_in;
      meet_ff       <= meet_in;
      sza_ff        <= sza_in;
      ap_ff         <= ap_in;
      bp_ff         <= bp_in;
      ap_none_ff    <= ap_none_in;
      bp_none_ff    <= bp_none_in;
      na_ff         <= na_in;
      nb_ff         <= nb_in;
      side_ff       <= side_in;
      removed_ff    <= removed_in;
      rsp_ff        <= rsp_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `IBC_ASSERT(a_rsp_idle, clock, reset, rsp_valid_ff |-> (state_ff == ST_IDLE), "result outside idle")
   `IBC_ASSERT(a_removed_merge, clock, reset, (rsp_valid_ff && (rsp_ff.event_kind != EV_MERGED)) |-> (rsp_ff.bridges_removed == '0), "removed count without merge")
   `IBC_ASSERT(a_bridge_upd, clock, reset, !$stable(bridge_ff) |-> rsp_valid_ff, "bridge total moved without result")
   `IBC_NEVER(a_rw_clash, clock, reset, vm_we && vm_re && (vm_waddr == vm_raddr), "read and write of one entry together")

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps
module tb;
   import ibc_pkg::*;

   localparam int NV = VERTICES_DEF;
   localparam int unsigned NONE = 32'hFFFF_FFFF;
   localparam int WATCH_LIMIT = 200000;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   req_type           req_data = '0;
   logic              rsp_valid;
   rsp_type           rsp_data;
   logic              psel = 1'b0;
   logic              penable = 1'b0;
   logic              pwrite = 1'b0;
   logic [CSR_AW-1:0] paddr = '0;
   logic [CSR_DW-1:0] pwdata = '0;
   logic [CSR_DW-1:0] prdata;
   logic              pready;

   incremental_bridge_counter dut (.*);

   always #5 clock = ~clock;

   // mirror of the graph state
   int unsigned parent_m [NV];
   int unsigned lead2_m [NV];
   int unsigned leadcc_m [NV];
   int unsigned size_m [NV];
   int unsigned mark_m [NV];
   int unsigned path_a [NV];
   int unsigned path_b [NV];
   int unsigned epoch_m;
   int unsigned bridges_m;
   int unsigned vcount_m;

   req_type edge_q [$];
   rsp_type outcome_q [$];
   int sender_idle;
   int mismatches = 0;
   int watch = 0;

   function automatic void init_mirror();
      foreach (parent_m[i]) begin
         parent_m[i] = NONE;
         lead2_m[i] = i;
         leadcc_m[i] = i;
         size_m[i] = 1;
         mark_m[i] = 0;
      end
      epoch_m = 0;
      bridges_m = 0;
   endfunction

   function automatic int unsigned find_2ec(int unsigned u);
      int unsigned r, steps, nx;
      r = u;
      steps = 0;
      if (u >= NV) return NONE;
      while (lead2_m[r] != r && steps < NV) begin
         nx = lead2_m[r];
         if (nx >= NV) break;
         r = nx;
         steps++;
      end
      steps = 0;
      while (u != r && u < NV && steps < NV) begin
         nx = lead2_m[u];
         lead2_m[u] = r;
         u = nx;
         steps++;
      end
      return r;
   endfunction

   function automatic int unsigned find_cc(int unsigned u);
      int unsigned r, cur, steps, nx;
      r = find_2ec(u);
      steps = 0;
      if (r == NONE) return NONE;
      while (leadcc_m[r] != r && steps < NV) begin
         nx = find_2ec(leadcc_m[r]);
         if (nx == NONE) break;
         r = nx;
         steps++;
      end
      cur = find_2ec(u);
      steps = 0;
      while (cur != r && cur != NONE && steps < NV) begin
         nx = leadcc_m[cur];
         leadcc_m[cur] = r;
         cur = find_2ec(nx);
         steps++;
      end
      return r;
   endfunction

   function automatic void reroot_tree(int unsigned u);
      int unsigned top, below, steps, up;
      top = u;
      below = NONE;
      steps = 0;
      while (u < NV && steps <= NV) begin
         up = find_2ec(parent_m[u]);
         parent_m[u] = below;
         leadcc_m[u] = top;
         below = u;
         u = up;
         steps++;
      end
      if (top < NV && below < NV) size_m[top] = size_m[below];
   endfunction

   function automatic int unsigned merge_cycle(int unsigned a, int unsigned b);
      int unsigned na, nb, meet, removed;
      na = 0;
      nb = 0;
      meet = NONE;
      removed = 0;
      epoch_m++;
      if (epoch_m == 0) begin
         foreach (mark_m[i]) mark_m[i] = 0;
         epoch_m = 1;
      end
      while (meet == NONE) begin
         if (a == NONE && b == NONE) break;
         if (a != NONE) begin
            a = find_2ec(a);
            if (a == NONE || na >= NV) break;
            path_a[na] = a;
            na++;
            if (mark_m[a] == epoch_m) begin
               meet = a;
               break;
            end
            mark_m[a] = epoch_m;
            a = parent_m[a];
         end
         if (b != NONE) begin
            b = find_2ec(b);
            if (b == NONE || nb >= NV) break;
            path_b[nb] = b;
            nb++;
            if (mark_m[b] == epoch_m) begin
               meet = b;
               break;
            end
            mark_m[b] = epoch_m;
            b = parent_m[b];
         end
      end
      if (meet == NONE) return 0;
      for (int unsigned i = 0; i < na; i++) begin
         lead2_m[path_a[i]] = meet;
         if (path_a[i] == meet) break;
         removed++;
      end
      for (int unsigned i = 0; i < nb; i++) begin
         lead2_m[path_b[i]] = meet;
         if (path_b[i] == meet) break;
         removed++;
      end
      bridges_m = (bridges_m > removed) ? bridges_m - removed : 0;
      return removed;
   endfunction

   function automatic rsp_type predict_edge(req_type e);
      int unsigned a, b, ca, cb, t, removed;
      event_type kind;
      rsp_type r;
      a = 32'(e.endpoint_a);
      b = 32'(e.endpoint_b);
      removed = 0;
      if (a >= vcount_m || b >= vcount_m) begin
         kind = EV_REJECT;
      end else begin
         a = find_2ec(a);
         b = find_2ec(b);
         if (a == b) begin
            kind = EV_IGNORED;
         end else begin
            ca = find_cc(a);
            cb = find_cc(b);
            if (ca != cb && ca < NV && cb < NV) begin
               bridges_m++;
               if (size_m[ca] > size_m[cb]) begin
                  t = a; a = b; b = t;
                  t = ca; ca = cb; cb = t;
               end
               reroot_tree(a);
               parent_m[a] = b;
               leadcc_m[a] = b;
               size_m[cb] += size_m[a];
               kind = EV_BRIDGE;
            end else begin
               removed = merge_cycle(a, b);
               kind = EV_MERGED;
            end
         end
      end
      r.bridge_count = bridges_m[COUNT_W-1:0];
      r.event_kind = kind;
      r.bridges_removed = removed[COUNT_W-1:0];
      return r;
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!start || !busy) begin
         if (edge_q.size() > 0 && $urandom_range(99) >= sender_idle) begin
            start <= 1'b1;
            req_data <= edge_q.pop_front();
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         init_mirror();
      end else begin
         if ((start && !busy) || rsp_valid) begin
            watch <= 0;
         end else begin
            watch <= watch + 1;
         end
         if (start && !busy) begin
            outcome_q.insert(outcome_q.size(), predict_edge(req_data));
         end
         if (rsp_valid) begin
            if (outcome_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected transfer %p", rsp_data);
            end else begin
               want = outcome_q.pop_front();
               if (rsp_data.bridge_count !== want.bridge_count ||
                   rsp_data.event_kind !== want.event_kind ||
                   rsp_data.bridges_removed !== want.bridges_removed) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: expected %p, got %p", want, rsp_data);
               end
            end
         end
         if (watch >= WATCH_LIMIT) begin
            $display("incremental_bridge_counter regression: fail");
            $finish;
         end
      end
   end

   task automatic write_vcount(int unsigned v);
      @(posedge clock);
      psel <= 1'b1;
      pwrite <= 1'b1;
      penable <= 1'b0;
      paddr <= '0;
      pwdata <= v;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      vcount_m = v & 32'h7FF;
   endtask

   task automatic drain();
      while (!(edge_q.size() == 0 && !start && outcome_q.size() == 0 && !busy))
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic push(int unsigned a, int unsigned b);
      req_type e;
      e.endpoint_a = EP_W'(a);
      e.endpoint_b = EP_W'(b);
      edge_q.insert(edge_q.size(), e);
   endtask

   task automatic random_burst(int n, int unsigned lim);
      int unsigned base, w;
      for (int i = 0; i < n; i++) begin
         if (i % 40 == 0) begin
            w = $urandom_range(32, 2);
            if (w > lim) w = lim;
            base = $urandom_range(lim - w);
         end
         if ($urandom_range(99) < 85)
            push(base + $urandom_range(w - 1), base + $urandom_range(w - 1));
         else
            push($urandom_range(1023), $urandom_range(1023));
      end
   endtask

   initial begin
      int unsigned vset [5] = '{1024, 40, 1024, 600, 1024};
      vcount_m = NV;
      sender_idle = 35;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      write_vcount(1024);
      push(0, 1); push(1, 2); push(2, 0); push(0, 0);
      push(1023, 1022); push(1023, 0); push(1022, 2); push(1023, 1023);
      push(512, 511); push(341, 682); push(511, 682);
      drain();
      write_vcount(3);
      push(5, 1); push(0, 3); push(0, 2); push(2, 2);
      drain();
      write_vcount(0);
      push(0, 0); push(1, 0);
      drain();
      write_vcount(1);
      push(0, 0); push(0, 1);
      drain();

      for (int p = 0; p < 5; p++) begin
         sender_idle = (p < 2) ? 35 : (p < 4) ? 66 : 0;
         write_vcount(vset[p]);
         random_burst(240, vset[p]);
         drain();
      end

      repeat (50) @(posedge clock);
      if (mismatches == 0 && outcome_q.size() == 0) begin
         $display("incremental_bridge_counter regression: pass");
      end else begin
         $display("incremental_bridge_counter regression: fail");
      end
      $finish;
   end

endmodule

[sim.f]
+incdir+src
src/ibc_pkg.sv
src/ibc_ram.sv
src/ibc_csr.sv
src/ibc_ctrl.sv
src/incremental_bridge_counter.sv
sim/tb.sv
